[hw/rtl/dpbp_pkg.sv]
`default_nettype none

package dpbp_pkg;

	// fixed field widths
	localparam int unsigned DEPTH_W    = 16;
	localparam int unsigned OUT_W      = 41;
	localparam int unsigned DIV_W      = 20;
	localparam int unsigned DIM_REG_W  = 13;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 20;

	// register reset values
	localparam logic [DIV_W-1:0]     FOCAL_X_RST  = 20'd83456;
	localparam logic [DIV_W-1:0]     FOCAL_Y_RST  = 20'd83456;
	localparam logic [DIV_W-1:0]     CENTRE_X_RST = 20'd40960;
	localparam logic [DIV_W-1:0]     CENTRE_Y_RST = 20'd30720;
	localparam logic [DIM_REG_W-1:0] FRAME_W_RST  = 13'd320;
	localparam logic [DIM_REG_W-1:0] FRAME_H_RST  = 13'd240;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCAL_X,
		CFG_FOCAL_Y,
		CFG_CENTRE_X,
		CFG_CENTRE_Y,
		CFG_FRAME_W,
		CFG_FRAME_H
	} cfg_reg_t;

	// control carried alongside the quotient bits through the divider chain
	typedef struct packed {
		logic               valid;
		logic               neg_x;
		logic               neg_y;
		logic [DEPTH_W-1:0] z;
	} ctl_t;

endpackage

`default_nettype wire

[hw/rtl/dpbp_div_cell.sv]
`default_nettype none

// one restoring division step for the x and y lanes
module dpbp_div_cell #(
	parameter int unsigned WORK_W = 44
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [dpbp_pkg::DIV_W-1:0] div_x,
	input  wire logic [dpbp_pkg::DIV_W-1:0] div_y,
	input  wire dpbp_pkg::ctl_t             ctl_in,
	input  wire logic [dpbp_pkg::DIV_W-1:0] rem_x_in,
	input  wire logic [dpbp_pkg::DIV_W-1:0] rem_y_in,
	input  wire logic [WORK_W-1:0]          work_x_in,
	input  wire logic [WORK_W-1:0]          work_y_in,
	output dpbp_pkg::ctl_t                  ctl_out,
	output logic [dpbp_pkg::DIV_W-1:0]      rem_x_out,
	output logic [dpbp_pkg::DIV_W-1:0]      rem_y_out,
	output logic [WORK_W-1:0]               work_x_out,
	output logic [WORK_W-1:0]               work_y_out
);
	import dpbp_pkg::*;

	logic [DIV_W:0]   sh_x, sh_y, trial_x, trial_y;
	logic             ge_x, ge_y;
	logic [DIV_W-1:0] rem_x_nxt, rem_y_nxt;

	ctl_t             ctl_q;
	logic [DIV_W-1:0] rem_x_q, rem_y_q;
	logic [WORK_W-1:0] work_x_q, work_y_q;

	// bring down the next dividend bit and try the subtraction
	always_comb begin
		sh_x      = {rem_x_in, work_x_in[WORK_W-1]};
		sh_y      = {rem_y_in, work_y_in[WORK_W-1]};
		trial_x   = sh_x - {1'b0, div_x};
		trial_y   = sh_y - {1'b0, div_y};
		ge_x      = ~trial_x[DIV_W];
		ge_y      = ~trial_y[DIV_W];
		rem_x_nxt = ge_x ? trial_x[DIV_W-1:0] : sh_x[DIV_W-1:0];
		rem_y_nxt = ge_y ? trial_y[DIV_W-1:0] : sh_y[DIV_W-1:0];
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// remainder and dividend/quotient shift word
	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_q  <= rem_x_nxt;
			rem_y_q  <= rem_y_nxt;
			work_x_q <= {work_x_in[WORK_W-2:0], ge_x};
			work_y_q <= {work_y_in[WORK_W-2:0], ge_y};
		end
	end

	assign ctl_out    = ctl_q;
	assign rem_x_out  = rem_x_q;
	assign rem_y_out  = rem_y_q;
	assign work_x_out = work_x_q;
	assign work_y_out = work_y_q;

endmodule

`default_nettype wire

[hw/rtl/depth_pixel_back_projection_core.sv]
// channel  | direction | handshake                | payload
// pixel    | in        | pixel_valid, pixel_stall | depth_low_byte, depth_high_byte
// point    | out       | point_valid, point_stall | point_x_mm_q8, point_y_mm_q8, point_z_mm
// cfg      | in        | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// one pixel per cycle while pixel_stall is low; a point passes the s1 and s2 front stages, then
// the row of NUM_W divider cells, one quotient bit each, then the output register
// zero-depth pixels only advance the column and row counters
// reset clears the counters and control, and loads the register defaults; no clearing pass
// a stalled point freezes the cell row only once a request reaches its last cell
`default_nettype none

module depth_pixel_back_projection_core #(
	parameter int unsigned MAX_FRAME_DIM = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pixel_valid,
	output logic                                  pixel_stall,
	input  wire logic [7:0]                       depth_low_byte,
	input  wire logic [7:0]                       depth_high_byte,
	output logic                                  point_valid,
	input  wire logic                             point_stall,
	output logic signed [dpbp_pkg::OUT_W-1:0]     point_x_mm_q8,
	output logic signed [dpbp_pkg::OUT_W-1:0]     point_y_mm_q8,
	output logic [dpbp_pkg::DEPTH_W-1:0]          point_z_mm,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dpbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dpbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dpbp_pkg::*;

	localparam int unsigned POS_W  = (MAX_FRAME_DIM > 2) ? $clog2(MAX_FRAME_DIM) : 1;
	localparam int unsigned CMP_W  = (POS_W + 1 > DIM_REG_W) ? POS_W + 1 : DIM_REG_W;
	localparam int unsigned DIFF_W = ((POS_W + 8 > DIV_W) ? POS_W + 8 : DIV_W) + 1;
	localparam int unsigned MAG_W  = DIFF_W - 1;
	localparam int unsigned PROD_W = MAG_W + DEPTH_W;
	localparam int unsigned NUM_W  = PROD_W + 8;

	// configuration registers
	logic [DIV_W-1:0]     focal_x_q, focal_y_q, centre_x_q, centre_y_q;
	logic [DIM_REG_W-1:0] frame_w_q, frame_h_q;

	// position counters
	logic [POS_W-1:0] col_q, row_q;

	// front stages
	logic                     valid_s1;
	logic signed [DIFF_W-1:0] diff_x_s1, diff_y_s1;
	logic [DEPTH_W-1:0]       depth_s1;
	ctl_t                     ctl_s2;
	logic [PROD_W-1:0]        prod_x_s2, prod_y_s2;

	logic               en, accept, load_out;
	logic [DEPTH_W-1:0] depth;
	logic [CMP_W-1:0]   eff_w, eff_h, col_inc, row_inc;
	logic [DIV_W-1:0]   div_x, div_y;
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic [DIFF_W-1:0]  abs_x, abs_y;

	// cell row
	ctl_t             ctl_c    [NUM_W+1];
	logic [DIV_W-1:0] rem_x_c  [NUM_W+1];
	logic [DIV_W-1:0] rem_y_c  [NUM_W+1];
	logic [NUM_W-1:0] work_x_c [NUM_W+1];
	logic [NUM_W-1:0] work_y_c [NUM_W+1];

	function automatic logic [OUT_W-1:0] signed_sat(input logic neg, input logic [NUM_W-1:0] q);
		logic hi;
		logic [OUT_W-1:0] r;
		hi = |q[NUM_W-1:OUT_W];
		if (neg) begin
			if (hi || (q[OUT_W-1] && (|q[OUT_W-2:0])))
				r = {1'b1, {(OUT_W-1){1'b0}}};
			else
				r = ~q[OUT_W-1:0] + 1'b1;
		end else begin
			if (hi || q[OUT_W-1])
				r = {1'b0, {(OUT_W-1){1'b1}}};
			else
				r = q[OUT_W-1:0];
		end
		return r;
	endfunction

	// flow control: hold only when the tail cell is occupied and the output is stalled
	assign load_out    = !(point_valid && point_stall);
	assign en          = load_out || !ctl_c[NUM_W].valid;
	assign pixel_stall = !en;
	assign accept      = pixel_valid && en;
	assign cfg_ready   = 1'b1;

	// frame size and divisor clamping, offsets from centre and their magnitudes
	always_comb begin
		depth   = {depth_high_byte, depth_low_byte};
		if (frame_w_q == '0)
			eff_w = CMP_W'(1);
		else if (CMP_W'(frame_w_q) > CMP_W'(MAX_FRAME_DIM))
			eff_w = CMP_W'(MAX_FRAME_DIM);
		else
			eff_w = CMP_W'(frame_w_q);
		if (frame_h_q == '0)
			eff_h = CMP_W'(1);
		else if (CMP_W'(frame_h_q) > CMP_W'(MAX_FRAME_DIM))
			eff_h = CMP_W'(MAX_FRAME_DIM);
		else
			eff_h = CMP_W'(frame_h_q);
		col_inc = CMP_W'(col_q) + 1'b1;
		row_inc = CMP_W'(row_q) + 1'b1;
		div_x   = (focal_x_q == '0) ? DIV_W'(1) : focal_x_q;
		div_y   = (focal_y_q == '0) ? DIV_W'(1) : focal_y_q;
		diff_x  = $signed(DIFF_W'({col_q, 8'h00})) - $signed(DIFF_W'(centre_x_q));
		diff_y  = $signed(DIFF_W'({row_q, 8'h00})) - $signed(DIFF_W'(centre_y_q));
		abs_x   = diff_x_s1[DIFF_W-1] ? DIFF_W'(-diff_x_s1) : DIFF_W'(diff_x_s1);
		abs_y   = diff_y_s1[DIFF_W-1] ? DIFF_W'(-diff_y_s1) : DIFF_W'(diff_y_s1);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			centre_x_q <= CENTRE_X_RST;
			centre_y_q <= CENTRE_Y_RST;
			frame_w_q  <= FRAME_W_RST;
			frame_h_q  <= FRAME_H_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				CFG_CENTRE_X: centre_x_q <= cfg_data;
				CFG_CENTRE_Y: centre_y_q <= cfg_data;
				CFG_FRAME_W:  frame_w_q  <= cfg_data[DIM_REG_W-1:0];
				CFG_FRAME_H:  frame_h_q  <= cfg_data[DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// raster counters, advanced by every request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				if (row_inc >= eff_h)
					row_q <= '0;
				else
					row_q <= row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[POS_W-1:0];
			end
		end
	end

	// front stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else if (en) begin
			valid_s1     <= accept && (depth != '0);
			ctl_s2.valid <= valid_s1;
			ctl_s2.neg_x <= diff_x_s1[DIFF_W-1];
			ctl_s2.neg_y <= diff_y_s1[DIFF_W-1];
			ctl_s2.z     <= depth_s1;
		end
	end

	// offset from centre, then magnitude times depth
	always_ff @(posedge clk) begin
		if (en) begin
			diff_x_s1    <= diff_x;
			diff_y_s1    <= diff_y;
			depth_s1     <= depth;
			prod_x_s2    <= PROD_W'(abs_x[MAG_W-1:0]) * PROD_W'(depth_s1);
			prod_y_s2    <= PROD_W'(abs_y[MAG_W-1:0]) * PROD_W'(depth_s1);
		end
	end

	// head of the cell row
	assign ctl_c[0]    = ctl_s2;
	assign rem_x_c[0]  = '0;
	assign rem_y_c[0]  = '0;
	assign work_x_c[0] = {prod_x_s2, 8'h00};
	assign work_y_c[0] = {prod_y_s2, 8'h00};

	// one cell per quotient bit
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		dpbp_div_cell #(
			.WORK_W(NUM_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.div_x      (div_x),
			.div_y      (div_y),
			.ctl_in     (ctl_c[i]),
			.rem_x_in   (rem_x_c[i]),
			.rem_y_in   (rem_y_c[i]),
			.work_x_in  (work_x_c[i]),
			.work_y_in  (work_y_c[i]),
			.ctl_out    (ctl_c[i+1]),
			.rem_x_out  (rem_x_c[i+1]),
			.rem_y_out  (rem_y_c[i+1]),
			.work_x_out (work_x_c[i+1]),
			.work_y_out (work_y_c[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else if (load_out) begin
			point_valid <= ctl_c[NUM_W].valid;
		end
	end

	// sign restore and saturation
	always_ff @(posedge clk) begin
		if (load_out) begin
			point_x_mm_q8 <= signed_sat(ctl_c[NUM_W].neg_x, work_x_c[NUM_W]);
			point_y_mm_q8 <= signed_sat(ctl_c[NUM_W].neg_y, work_y_c[NUM_W]);
			point_z_mm    <= ctl_c[NUM_W].z;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dpbp_checker.sv]
`default_nettype none

module dpbp_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             pixel_valid,
	input wire logic                             pixel_stall,
	input wire logic                             point_valid,
	input wire logic                             point_stall,
	input wire logic signed [dpbp_pkg::OUT_W-1:0] point_x_mm_q8,
	input wire logic signed [dpbp_pkg::OUT_W-1:0] point_y_mm_q8,
	input wire logic [dpbp_pkg::DEPTH_W-1:0]     point_z_mm
);
	import dpbp_pkg::*;

	// a held point keeps its payload
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point_x_mm_q8)
			&& $stable(point_y_mm_q8) && $stable(point_z_mm))
		else $error("held point changed");

	// requests are refused only behind a held point
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> point_valid && point_stall)
		else $error("pixel stall without held point");

	// zero depth never leaves the block
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> point_z_mm != '0)
		else $error("point with zero depth");

	// nothing offered while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !point_valid)
		else $error("point offered during reset");

endmodule

bind depth_pixel_back_projection_core dpbp_checker u_dpbp_checker (.*);

`default_nettype wire

[tb/sv/dpbp_point_checker.sv]
`timescale 1ns / 100ps

module dpbp_point_checker
	import dpbp_pkg::*;
#(
	parameter int unsigned MAX_FRAME_DIM = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pixel_valid,
	input  wire logic                          pixel_stall,
	input  wire logic [7:0]                    depth_low_byte,
	input  wire logic [7:0]                    depth_high_byte,
	input  wire logic                          point_valid,
	input  wire logic                          point_stall,
	input  wire logic signed [OUT_W-1:0]       point_x_mm_q8,
	input  wire logic signed [OUT_W-1:0]       point_y_mm_q8,
	input  wire logic [DEPTH_W-1:0]            point_z_mm,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	output int                                 mismatch_count,
	output int                                 points_pending
);

	localparam longint POINT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint POINT_MIN = -(longint'(1) <<< (OUT_W - 1));

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [DEPTH_W-1:0]      z;
	} point_t;

	point_t               expected_points[$];
	point_t               next_point;
	logic [DEPTH_W-1:0]   depth;
	logic [DIV_W-1:0]     focal_x, focal_y, centre_x, centre_y;
	logic [DIM_REG_W-1:0] frame_w, frame_h;
	int unsigned          column, row;

	// zero acts as one, oversize clamps to the largest frame
	function automatic int unsigned clamp_dim(input logic [DIM_REG_W-1:0] dim);
		if (dim == '0) return 1;
		if (dim > MAX_FRAME_DIM) return MAX_FRAME_DIM;
		return dim;
	endfunction

	// (pos - centre) * depth / focal in Q8 mm, truncated toward zero, saturated
	function automatic logic signed [OUT_W-1:0] project_axis(
		input int unsigned pos,
		input logic [DIV_W-1:0] centre,
		input logic [DIV_W-1:0] focal,
		input logic [DEPTH_W-1:0] depth_mm
	);
		longint offset;
		longint quotient;
		offset = longint'(pos) * 256 - longint'(centre);
		quotient = offset * longint'(depth_mm) * 256 /
			((focal == '0) ? longint'(1) : longint'(focal));
		if (quotient > POINT_MAX) quotient = POINT_MAX;
		else if (quotient < POINT_MIN) quotient = POINT_MIN;
		return quotient[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x = FOCAL_X_RST;
			focal_y = FOCAL_Y_RST;
			centre_x = CENTRE_X_RST;
			centre_y = CENTRE_Y_RST;
			frame_w = FRAME_W_RST;
			frame_h = FRAME_H_RST;
			column = 0;
			row = 0;
			expected_points.delete();
			mismatch_count = 0;
			points_pending = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FOCAL_X:  focal_x = cfg_data[DIV_W-1:0];
					CFG_FOCAL_Y:  focal_y = cfg_data[DIV_W-1:0];
					CFG_CENTRE_X: centre_x = cfg_data[DIV_W-1:0];
					CFG_CENTRE_Y: centre_y = cfg_data[DIV_W-1:0];
					CFG_FRAME_W:  frame_w = cfg_data[DIM_REG_W-1:0];
					CFG_FRAME_H:  frame_h = cfg_data[DIM_REG_W-1:0];
					default: ;
				endcase
			end

			// pixel request: predict its point, then step the raster position
			if (pixel_valid && !pixel_stall) begin
				depth = {depth_high_byte, depth_low_byte};
				if (depth != '0) begin
					next_point.x = project_axis(column, centre_x, focal_x, depth);
					next_point.y = project_axis(row, centre_y, focal_y, depth);
					next_point.z = depth;
					expected_points.push_back(next_point);
				end
				if (column + 1 >= clamp_dim(frame_w)) begin
					column = 0;
					if (row + 1 >= clamp_dim(frame_h)) row = 0;
					else row = row + 1;
				end else begin
					column = column + 1;
				end
			end

			// point request: compare with the oldest prediction
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					$error("point with no pixel behind it: x %0d, y %0d, z %0d",
						point_x_mm_q8, point_y_mm_q8, point_z_mm);
					mismatch_count++;
				end else begin
					next_point = expected_points.pop_front();
					if (point_x_mm_q8 !== next_point.x) begin
						$error("point_x_mm_q8 mismatch: expected %0d, actual %0d",
							next_point.x, point_x_mm_q8);
						mismatch_count++;
					end
					if (point_y_mm_q8 !== next_point.y) begin
						$error("point_y_mm_q8 mismatch: expected %0d, actual %0d",
							next_point.y, point_y_mm_q8);
						mismatch_count++;
					end
					if (point_z_mm !== next_point.z) begin
						$error("point_z_mm mismatch: expected %0d, actual %0d",
							next_point.z, point_z_mm);
						mismatch_count++;
					end
				end
			end
			points_pending = expected_points.size();
		end
	end

endmodule

[tb/sv/depth_pixel_back_projection_core_tb.sv]
`timescale 1ns / 100ps

module depth_pixel_back_projection_core_tb;
	import dpbp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_PERCENT = 32;
	localparam int unsigned PAD_W        = CFG_DATA_W - DIM_REG_W;
	// indexes past the last register, which the block ignores
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam logic [DEPTH_W-1:0] EXTREME_DEPTHS [8] = '{
		16'h0000, 16'h0001, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8000, 16'h7FFF, 16'h0000
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          pixel_valid;
	logic                          pixel_stall;
	logic [7:0]                    depth_low_byte;
	logic [7:0]                    depth_high_byte;
	logic                          point_valid;
	logic                          point_stall;
	logic signed [OUT_W-1:0]       point_x_mm_q8;
	logic signed [OUT_W-1:0]       point_y_mm_q8;
	logic [DEPTH_W-1:0]            point_z_mm;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;

	logic        tx_idles = 1'b1;
	logic        rx_idles = 1'b1;
	logic        hold_req = 1'b0;
	logic        hold_served;
	int unsigned cycle_count = 0;
	int          mismatch_count;
	int          points_pending;

	always #5 clk = ~clk;

	depth_pixel_back_projection_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.depth_low_byte  (depth_low_byte),
		.depth_high_byte (depth_high_byte),
		.point_valid     (point_valid),
		.point_stall     (point_stall),
		.point_x_mm_q8   (point_x_mm_q8),
		.point_y_mm_q8   (point_y_mm_q8),
		.point_z_mm      (point_z_mm),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	dpbp_point_checker point_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.depth_low_byte  (depth_low_byte),
		.depth_high_byte (depth_high_byte),
		.point_valid     (point_valid),
		.point_stall     (point_stall),
		.point_x_mm_q8   (point_x_mm_q8),
		.point_y_mm_q8   (point_y_mm_q8),
		.point_z_mm      (point_z_mm),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.points_pending  (points_pending)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("depth_pixel_back_projection_core test failed");
			$finish;
		end
	end

	// point receiver: random stalls and one long hold-off
	initial begin
		point_stall = 1'b0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				point_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			point_stall <= rx_idles && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [DEPTH_W-1:0] depth);
		if (tx_idles) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				pixel_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pixel_valid <= 1'b1;
		depth_low_byte <= depth[7:0];
		depth_high_byte <= depth[15:8];
		do @(posedge clk); while (pixel_stall);
	endtask

	// stop offering and let the divider row empty out; step the clock first so the
	// last request is already counted as pending
	task automatic wait_pipeline_empty();
		pixel_valid <= 1'b0;
		@(posedge clk);
		wait (points_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly full-range depths, with zero pixels, low-byte-only and extremes mixed in
	function automatic logic [DEPTH_W-1:0] pick_depth();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 15) return '0;
		if (roll < 25) return DEPTH_W'($urandom_range(255));
		if (roll < 30) return ($urandom_range(1) == 1) ? '1 : DEPTH_W'(1);
		return DEPTH_W'($urandom);
	endfunction

	// below 256 overflows, so keep it to a quarter of the picks
	function automatic logic [DIV_W-1:0] pick_focal();
		int unsigned roll;
		roll = $urandom_range(3);
		if (roll == 0) return DIV_W'($urandom_range(255));
		if (roll == 1) return DIV_W'($urandom_range(4095, 256));
		return DIV_W'($urandom_range(1048575, 256));
	endfunction

	function automatic logic [DIV_W-1:0] pick_centre(input int unsigned dim);
		if ($urandom_range(1) == 1) return DIV_W'($urandom_range(dim * 256, 0));
		return DIV_W'($urandom);
	endfunction

	// small frames mostly, so both counters wrap often
	task automatic randomise_config();
		int unsigned width;
		int unsigned height;
		width = ($urandom_range(9) == 0) ? $urandom_range(4096, 1) : $urandom_range(40, 1);
		height = ($urandom_range(3) == 0) ? $urandom_range(300, 1) : $urandom_range(12, 1);
		write_reg(CFG_FOCAL_X, pick_focal());
		write_reg(CFG_FOCAL_Y, pick_focal());
		write_reg(CFG_CENTRE_X, pick_centre(width));
		write_reg(CFG_CENTRE_Y, pick_centre(height));
		write_reg(CFG_FRAME_W, {PAD_W'($urandom), DIM_REG_W'(width)});
		write_reg(CFG_FRAME_H, {PAD_W'($urandom), DIM_REG_W'(height)});
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		depth_low_byte = '0;
		depth_high_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, depth extremes
		for (int i = 0; i < 8; i++) send_pixel(EXTREME_DEPTHS[i]);
		wait_pipeline_empty();

		// zero frame size and zero or tiny focal lengths: counters stay put, x saturates at full depth
		write_reg(CFG_FOCAL_X, '0);
		write_reg(CFG_FOCAL_Y, CFG_DATA_W'(255));
		write_reg(CFG_CENTRE_X, '1);
		write_reg(CFG_CENTRE_Y, '1);
		write_reg(CFG_FRAME_W, '0);
		write_reg(CFG_FRAME_H, '0);
		write_reg(CFG_SPARE_A, '1);
		write_reg(CFG_SPARE_B, '0);
		send_pixel('1);
		send_pixel(DEPTH_W'(1));
		send_pixel('0);
		wait_pipeline_empty();

		// oversized frame, then shrink width and height below the current position
		write_reg(CFG_FOCAL_X, '1);
		write_reg(CFG_FOCAL_Y, CFG_DATA_W'(256));
		write_reg(CFG_CENTRE_X, '0);
		write_reg(CFG_CENTRE_Y, '0);
		write_reg(CFG_FRAME_W, '1);
		write_reg(CFG_FRAME_H, CFG_DATA_W'(4097));
		for (int i = 0; i < 5; i++) send_pixel(pick_depth());
		wait_pipeline_empty();
		write_reg(CFG_FRAME_W, CFG_DATA_W'(3));
		for (int i = 0; i < 3; i++) send_pixel(pick_depth());
		wait_pipeline_empty();
		write_reg(CFG_FRAME_H, CFG_DATA_W'(1));
		for (int i = 0; i < 4; i++) send_pixel(pick_depth());

		// random settings; phase 2 runs with no idling on either side
		for (int phase = 0; phase < 7; phase++) begin
			wait_pipeline_empty();
			randomise_config();
			tx_idles = (phase != 2);
			rx_idles <= (phase != 2);
			for (int n = 0; n < 130; n++) begin
				if (phase == 4 && n == 60) begin
					// sender pauses until every point is out
					pixel_valid <= 1'b0;
					@(posedge clk);
					wait (points_pending == 0);
					@(posedge clk);
				end
				send_pixel(pick_depth());
			end
		end

		// one-pixel-wide strip: rows climb fast, so y saturates high;
		// receiver holds off while the sender keeps offering
		wait_pipeline_empty();
		write_reg(CFG_FOCAL_X, pick_focal());
		write_reg(CFG_FOCAL_Y, CFG_DATA_W'(1));
		write_reg(CFG_CENTRE_X, pick_centre(1));
		write_reg(CFG_CENTRE_Y, '0);
		write_reg(CFG_FRAME_W, CFG_DATA_W'(1));
		write_reg(CFG_FRAME_H, CFG_DATA_W'(4096));
		tx_idles = 1'b0;
		rx_idles <= 1'b1;
		hold_req <= 1'b1;
		for (int n = 0; n < 400; n++) send_pixel(pick_depth());
		wait_pipeline_empty();

		if (mismatch_count == 0 && points_pending == 0) begin
			$display("depth_pixel_back_projection_core test passed");
		end else begin
			$display("depth_pixel_back_projection_core test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/dpbp_pkg.sv
hw/rtl/dpbp_div_cell.sv
hw/rtl/depth_pixel_back_projection_core.sv
hw/rtl/dpbp_checker.sv
tb/sv/dpbp_point_checker.sv
tb/sv/depth_pixel_back_projection_core_tb.sv
